// ----- hw/rtl/crfw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfw_pkg
// Types and constants shared by the cubic filter weight pipeline, its
// channel interfaces and its checker.
// ----------------------------------------------------------------------------
package crfw_pkg;

	// Word and register port widths
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE = 2'd0,
		CFG_B     = 2'd1,
		CFG_C     = 2'd2
	} cfg_reg_t;

	// Register reset values
	localparam logic [DATA_W-1:0]        SCALE_RST = 16'd4096;
	localparam logic signed [DATA_W-1:0] B_RST     = 16'sd5461;
	localparam logic signed [DATA_W-1:0] C_RST     = 16'sd5461;

	// Which piece of the kernel a distance falls in
	typedef enum logic [1:0] {
		RGN_INNER,
		RGN_OUTER,
		RGN_ZERO
	} region_t;

	// Pipeline depth, accept to result register
	localparam int unsigned PIPE_DEPTH = 9;

	// Datapath widths
	localparam int unsigned MAG_W   = DATA_W + 1;           // |offset|, up to 32768
	localparam int unsigned PROD_W  = MAG_W + DATA_W;       // |offset| * scale, Q24
	localparam int unsigned FRAC_W  = 14;                   // Q14 fraction bits
	localparam int unsigned T_W     = 15;                   // t below 2.0 in Q14
	localparam int unsigned COEF_W  = 23;                   // cubic coefficients
	localparam int unsigned SUM_W   = 26;                   // Horner partial sums
	localparam int unsigned P3_W    = COEF_W + T_W + 1;     // first Horner product
	localparam int unsigned PP_W    = SUM_W + T_W + 1;      // later Horner products
	localparam int unsigned Y_W     = 19;                   // biased clamped sum
	localparam int unsigned RECIP_SHIFT = 21;
	localparam int unsigned Q_W     = 2 * Y_W;

	localparam logic signed [COEF_W-1:0] ONE_Q14 = COEF_W'(16384);

	// Constant parts of the inner cubic
	localparam logic signed [COEF_W-1:0] INNER_A3_BASE = COEF_W'(12 * 16384);
	localparam logic signed [COEF_W-1:0] INNER_A2_BASE = COEF_W'(-18 * 16384);
	localparam logic signed [COEF_W-1:0] INNER_A0_BASE = COEF_W'(6 * 16384);

	// Rounding bias for a Q28 to Q14 step
	localparam logic signed [PP_W-1:0] HALF_Q14 = PP_W'(8192);

	// Final divide by six: clamp window, bias and reciprocal
	localparam logic signed [SUM_W:0] SUM_MAX  = (SUM_W+1)'(196607);
	localparam logic signed [SUM_W:0] SUM_MIN  = (SUM_W+1)'(-196608);
	localparam logic signed [SUM_W:0] ROUND_SIX = (SUM_W+1)'(3);
	localparam logic [Y_W-1:0]        RECIP_SIX = 19'd349526;

	typedef struct packed {
		logic signed [COEF_W-1:0] a3;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a0;
	} coef_t;

	// Divide a Q28 product by 2^14, round to nearest, ties up
	function automatic logic signed [SUM_W-1:0] round_q14(input logic signed [PP_W-1:0] v);
		logic signed [PP_W-1:0] r;
		r = v + HALF_Q14;
		return SUM_W'(r >>> FRAC_W);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crfw_offset_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfw_offset_if
// Valid/ready channel carrying one sample offset word.
// ----------------------------------------------------------------------------
interface crfw_offset_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [crfw_pkg::DATA_W-1:0]   offset;

	modport source (output valid, output offset, input ready);
	modport sink   (input valid, input offset, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/crfw_weight_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfw_weight_if
// Valid/ready channel carrying one filter weight word.
// ----------------------------------------------------------------------------
interface crfw_weight_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [crfw_pkg::DATA_W-1:0]   weight;

	modport source (output valid, output weight, input ready);
	modport sink   (input valid, input weight, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cubic_reconstruction_filter_weight.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle unless every stage holds a word and the
// weight word is stalled; each stage advances on its own, so bubbles fill
// up and the input keeps taking words while a finished weight waits.
// Nine stages: magnitude, scale, Horner steps, clamp, divide.
// Reset: arst_n clears all stage valid bits and restores scale, B and C to
// their defaults; no clearing pass, the block takes words right after reset.
// ----------------------------------------------------------------------------
// cubic_reconstruction_filter_weight
// Mitchell-Netravali cubic weight in fixed point: scale |offset|, pick the
// inner or outer cubic, evaluate by Horner, divide by six and saturate.
// ----------------------------------------------------------------------------
module cubic_reconstruction_filter_weight (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	crfw_offset_if.sink                          sample,
	crfw_weight_if.source                        result,
	input  wire logic                            cfg_we,
	input  wire logic [crfw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [crfw_pkg::DATA_W-1:0]     cfg_data
);

	localparam int unsigned D  = crfw_pkg::PIPE_DEPTH;
	localparam int unsigned CW = crfw_pkg::COEF_W;
	localparam int unsigned SW = crfw_pkg::SUM_W;

	// Configuration registers
	logic [crfw_pkg::DATA_W-1:0]        scale_q;
	logic signed [crfw_pkg::DATA_W-1:0] b_q;
	logic signed [crfw_pkg::DATA_W-1:0] c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= crfw_pkg::SCALE_RST;
			b_q     <= crfw_pkg::B_RST;
			c_q     <= crfw_pkg::C_RST;
		end else if (cfg_we) begin
			unique case (crfw_pkg::cfg_reg_t'(cfg_index))
				crfw_pkg::CFG_SCALE: scale_q <= cfg_data;
				crfw_pkg::CFG_B:     b_q     <= cfg_data;
				crfw_pkg::CFG_C:     c_q     <= cfg_data;
				default:             ;
			endcase
		end
	end

	// Derive both coefficient sets from B and C (shift-add multiples)
	logic signed [CW-1:0] b_x, c_x;
	crfw_pkg::coef_t      inner_d, outer_d;
	crfw_pkg::coef_t      inner_q, outer_q;

	always_comb begin
		b_x = {{(CW-crfw_pkg::DATA_W){b_q[crfw_pkg::DATA_W-1]}}, b_q};
		c_x = {{(CW-crfw_pkg::DATA_W){c_q[crfw_pkg::DATA_W-1]}}, c_q};
		inner_d.a3 = crfw_pkg::INNER_A3_BASE - (b_x <<< 3) - b_x - (c_x <<< 2) - (c_x <<< 1);
		inner_d.a2 = crfw_pkg::INNER_A2_BASE + (b_x <<< 3) + (b_x <<< 2)
			+ (c_x <<< 2) + (c_x <<< 1);
		inner_d.a1 = '0;
		inner_d.a0 = crfw_pkg::INNER_A0_BASE - (b_x <<< 1);
		outer_d.a3 = -b_x - (c_x <<< 2) - (c_x <<< 1);
		outer_d.a2 = (b_x <<< 2) + (b_x <<< 1) + (c_x <<< 5) - (c_x <<< 1);
		outer_d.a1 = -(b_x <<< 3) - (b_x <<< 2) - (c_x <<< 5) - (c_x <<< 4);
		outer_d.a0 = (b_x <<< 3) + (c_x <<< 4) + (c_x <<< 3);
	end

	// Hold coefficients in registers; they settle in the cycle after the written register changes
	always_ff @(posedge clk) begin
		inner_q <= inner_d;
		outer_q <= outer_d;
	end

	// Stage valid bits and per-stage advance
	logic [D-1:0] vld_q;
	logic [D-1:0] en;

	always_comb begin
		en[D-1] = !vld_q[D-1] || result.ready;
		for (int k = D - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < D; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = en[0];
	assign result.valid = vld_q[D-1];

	// Stage 1: magnitude of the offset
	logic [crfw_pkg::MAG_W-1:0] off_x;
	logic [crfw_pkg::MAG_W-1:0] mag_s1;

	assign off_x = {sample.offset[crfw_pkg::DATA_W-1], sample.offset};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1 <= sample.offset[crfw_pkg::DATA_W-1] ? (~off_x + 1'b1) : off_x;
		end
	end

	// Stage 2: scale to the normalized distance, Q24
	logic [crfw_pkg::PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= crfw_pkg::PROD_W'(mag_s1) * crfw_pkg::PROD_W'(scale_q);
		end
	end

	// Stage 3: classify, take t in Q14, first Horner multiply
	crfw_pkg::region_t             rgn_d;
	logic [crfw_pkg::T_W-1:0]      t_d;
	logic signed [CW-1:0]          a3_sel;
	logic signed [crfw_pkg::T_W:0] t_sg_d;

	always_comb begin
		priority if (prod_s2[crfw_pkg::PROD_W-1:crfw_pkg::FRAC_W+11] != '0) begin
			rgn_d = crfw_pkg::RGN_ZERO;
		end else if (prod_s2[crfw_pkg::FRAC_W+10]) begin
			rgn_d = crfw_pkg::RGN_OUTER;
		end else begin
			rgn_d = crfw_pkg::RGN_INNER;
		end
		t_d    = prod_s2[crfw_pkg::FRAC_W+10:10];
		t_sg_d = {1'b0, t_d};
		a3_sel = (rgn_d == crfw_pkg::RGN_INNER) ? inner_q.a3 : outer_q.a3;
	end

	crfw_pkg::region_t                rgn_s3;
	logic [crfw_pkg::T_W-1:0]         t_s3;
	logic signed [crfw_pkg::P3_W-1:0] p_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rgn_s3 <= rgn_d;
			t_s3   <= t_d;
			p_s3   <= a3_sel * t_sg_d;
		end
	end

	// Stage 4: round and add a2
	logic signed [crfw_pkg::PP_W-1:0] p3_x;
	logic signed [CW-1:0]             a2_sel;
	crfw_pkg::region_t                rgn_s4;
	logic [crfw_pkg::T_W-1:0]         t_s4;
	logic signed [SW-1:0]             s_s4;

	assign p3_x   = {{(crfw_pkg::PP_W-crfw_pkg::P3_W){p_s3[crfw_pkg::P3_W-1]}}, p_s3};
	assign a2_sel = (rgn_s3 == crfw_pkg::RGN_INNER) ? inner_q.a2 : outer_q.a2;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rgn_s4 <= rgn_s3;
			t_s4   <= t_s3;
			s_s4   <= crfw_pkg::round_q14(p3_x) + {{(SW-CW){a2_sel[CW-1]}}, a2_sel};
		end
	end

	// Stage 5: second Horner multiply
	crfw_pkg::region_t                rgn_s5;
	logic [crfw_pkg::T_W-1:0]         t_s5;
	logic signed [crfw_pkg::PP_W-1:0] p_s5;
	logic signed [crfw_pkg::T_W:0]    t4_sg;

	assign t4_sg = {1'b0, t_s4};

	always_ff @(posedge clk) begin
		if (en[4]) begin
			rgn_s5 <= rgn_s4;
			t_s5   <= t_s4;
			p_s5   <= s_s4 * t4_sg;
		end
	end

	// Stage 6: round and add a1
	logic signed [CW-1:0]     a1_sel;
	crfw_pkg::region_t        rgn_s6;
	logic [crfw_pkg::T_W-1:0] t_s6;
	logic signed [SW-1:0]     s_s6;

	assign a1_sel = (rgn_s5 == crfw_pkg::RGN_INNER) ? inner_q.a1 : outer_q.a1;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			rgn_s6 <= rgn_s5;
			t_s6   <= t_s5;
			s_s6   <= crfw_pkg::round_q14(p_s5) + {{(SW-CW){a1_sel[CW-1]}}, a1_sel};
		end
	end

	// Stage 7: third Horner multiply
	crfw_pkg::region_t                rgn_s7;
	logic signed [crfw_pkg::PP_W-1:0] p_s7;
	logic signed [crfw_pkg::T_W:0]    t6_sg;

	assign t6_sg = {1'b0, t_s6};

	always_ff @(posedge clk) begin
		if (en[6]) begin
			rgn_s7 <= rgn_s6;
			p_s7   <= s_s6 * t6_sg;
		end
	end

	// Stage 8: add a0, zero outside the support, clamp and bias for divide
	logic signed [CW-1:0]   a0_sel;
	logic signed [SW-1:0]   s_fin;
	logic signed [SW:0]     x_d;
	logic signed [SW:0]     x_cl;
	logic signed [SW:0]     y_full;
	logic [crfw_pkg::Y_W-1:0] y_s8;

	always_comb begin
		a0_sel = (rgn_s7 == crfw_pkg::RGN_INNER) ? inner_q.a0 : outer_q.a0;
		s_fin  = crfw_pkg::round_q14(p_s7) + {{(SW-CW){a0_sel[CW-1]}}, a0_sel};
		if (rgn_s7 == crfw_pkg::RGN_ZERO) begin
			s_fin = '0;
		end
		x_d = {s_fin[SW-1], s_fin} + crfw_pkg::ROUND_SIX;
		priority if (x_d > crfw_pkg::SUM_MAX) begin
			x_cl = crfw_pkg::SUM_MAX;
		end else if (x_d < crfw_pkg::SUM_MIN) begin
			x_cl = crfw_pkg::SUM_MIN;
		end else begin
			x_cl = x_d;
		end
		y_full = x_cl - crfw_pkg::SUM_MIN;
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			y_s8 <= y_full[crfw_pkg::Y_W-1:0];
		end
	end

	// Stage 9: floor divide by six via reciprocal, remove bias
	logic [crfw_pkg::Q_W-1:0]    q_d;
	logic [crfw_pkg::DATA_W-1:0] qq_d;
	logic signed [crfw_pkg::DATA_W-1:0] weight_s9;

	always_comb begin
		q_d  = crfw_pkg::Q_W'(y_s8) * crfw_pkg::Q_W'(crfw_pkg::RECIP_SIX);
		qq_d = q_d[crfw_pkg::RECIP_SHIFT+crfw_pkg::DATA_W-1:crfw_pkg::RECIP_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			weight_s9 <= {~qq_d[crfw_pkg::DATA_W-1], qq_d[crfw_pkg::DATA_W-2:0]};
		end
	end

	assign result.weight = weight_s9;

endmodule
`default_nettype wire

// ----- hw/rtl/crfw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfw_checker
// Port-level checks on the filter weight pipeline: output hold under stall,
// words in flight bounded by the pipeline depth, no weight word without an offset
// word in flight, and input backpressure.
module crfw_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           sample_valid,
	input wire logic                           sample_ready,
	input wire logic                           result_valid,
	input wire logic                           result_ready,
	input wire logic [crfw_pkg::DATA_W-1:0]    weight
);

	localparam int unsigned CNT_W = $clog2(crfw_pkg::PIPE_DEPTH + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] cnt_q;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = result_valid && result_ready;

	// Track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("weight word dropped while stalled");

	a_hold_weight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(weight))
		else $error("weight changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != '0)
		else $error("weight word with no offset word in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(crfw_pkg::PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("input stalled without a stalled output");

endmodule

bind cubic_reconstruction_filter_weight crfw_checker u_crfw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.weight       (result.weight)
);
`default_nettype wire
